>>> design/assert_macros.svh
// Assertion macros shared by the quaternion normaliser RTL.
// Depends on nothing; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> design/qn_pkg.sv
// Shared constants for the quaternion normaliser.
// No dependencies.
package qn_pkg;
  localparam int COMP_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int MIN_MOD_W     = 16;
endpackage

>>> design/qn_sqrt_cell.sv
// One step of the digit-by-digit square root: two radicand bits per cell.
// Depends on qn_pkg.
module qn_sqrt_cell #(
  parameter int RW = 17,
  parameter int PW = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  logic [2*RW-1:0] n_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            vld_o,
  output logic [2*RW-1:0] n_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);
  import qn_pkg::*;

  logic            vld_r;
  logic [2*RW-1:0] n_r, n_nxt;
  logic [RW+1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [RW-1:0]   root_r, root_nxt;
  logic [PW-1:0]   pay_r;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_i[RW-1:0], n_i[2*RW-1 -: 2]};
    trial    = {root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[RW-2:0], ge};
    n_nxt    = {n_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    pay_r  <= pay_i;
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;
endmodule

>>> design/qn_div_cell.sv
// One restoring-division step for all four components: one quotient bit each.
// Depends on qn_pkg.
module qn_div_cell #(
  parameter int CB = 16,
  parameter int DW = 30,
  parameter int PW = 65
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [CB-1:0]       d_i,
  input  logic [3:0][DW-1:0]  dvd_i,
  input  logic [3:0][CB:0]    rem_i,
  input  logic [3:0][DW-1:0]  q_i,
  input  logic [PW-1:0]       pay_i,
  output logic                vld_o,
  output logic [CB-1:0]       d_o,
  output logic [3:0][DW-1:0]  dvd_o,
  output logic [3:0][CB:0]    rem_o,
  output logic [3:0][DW-1:0]  q_o,
  output logic [PW-1:0]       pay_o
);
  import qn_pkg::*;

  logic               vld_r;
  logic [CB-1:0]      d_r;
  logic [3:0][DW-1:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic [3:0][CB:0]   rem_r, rem_nxt, rs;
  logic [PW-1:0]      pay_r;
  logic [3:0]         ge;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rs[l]      = {rem_i[l][CB-1:0], dvd_i[l][DW-1]};
      ge[l]      = (rs[l] >= {1'b0, d_i});
      rem_nxt[l] = ge[l] ? (rs[l] - {1'b0, d_i}) : rs[l];
      q_nxt[l]   = {q_i[l][DW-2:0], ge[l]};
      dvd_nxt[l] = {dvd_i[l][DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_i;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    pay_r <= pay_i;
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
  assign dvd_o = dvd_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign pay_o = pay_r;
endmodule

>>> design/quaternion_normalizer_top.sv
// Quaternion normaliser: squares, sum, square-root chain, divider chain.
// Depends on qn_pkg, qn_sqrt_cell, qn_div_cell and assert_macros.svh.
//
// Usage:
//   Input: drive in_comp_* and pulse start; a transfer happens when start is
//   high and busy is low. busy never rises, so one quaternion can be taken
//   every cycle.
//   Output: out_valid is high for exactly one cycle with out_norm_*,
//   out_magnitude and out_was_scaled; there is no back-pressure.
//   Pipeline: COMP_BITS + 1 root cells plus COMP_BITS + FRAC_BITS divider
//   cells plus five register stages. Throughput is one item per cycle,
//   set by the two cell chains, one stage per bit.
//   Config: cfg_min_modulus is written when cfg_valid is high (cfg_ready is
//   always high); write it only while no item is in flight.
//   Reset: synchronous on rst_n low; clears the in-flight valid bits and
//   sets min_modulus to zero.
`include "assert_macros.svh"
module quaternion_normalizer_top #(
  parameter int COMP_BITS = qn_pkg::COMP_BITS_DEF,
  parameter int FRAC_BITS = qn_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COMP_BITS-1:0] in_comp_w,
  input  logic signed [COMP_BITS-1:0] in_comp_x,
  input  logic signed [COMP_BITS-1:0] in_comp_y,
  input  logic signed [COMP_BITS-1:0] in_comp_z,
  output logic                        out_valid,
  output logic signed [COMP_BITS-1:0] out_norm_w,
  output logic signed [COMP_BITS-1:0] out_norm_x,
  output logic signed [COMP_BITS-1:0] out_norm_y,
  output logic signed [COMP_BITS-1:0] out_norm_z,
  output logic [COMP_BITS-1:0]        out_magnitude,
  output logic                        out_was_scaled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qn_pkg::MIN_MOD_W-1:0] cfg_min_modulus
);
  import qn_pkg::*;

  localparam int CB  = COMP_BITS;
  localparam int SQW = 2*CB - 1;
  localparam int SW  = 2*CB + 1;
  localparam int RW  = CB + 1;
  localparam int DW  = CB + FRAC_BITS;
  localparam int PW  = 4*CB;
  localparam int DPW = 4*CB + 1;
  localparam int MW  = (CB > MIN_MOD_W) ? CB : MIN_MOD_W;
  localparam int LAT = RW + DW + 5;
  localparam logic [DW-1:0] SIGN_Q = DW'(1) << (CB-1);
  localparam logic [DW-1:0] MAXP_Q = SIGN_Q - DW'(1);

  logic [MIN_MOD_W-1:0] min_mod_r;
  logic                 v0_r, v1_r, v2_r, vm_r, vo_r;
  logic [3:0][CB-1:0]   c0_r, c1_r, c2_r, cm_r;
  logic [3:0][CB-1:0]   mag0;
  logic [3:0][SQW-1:0]  sq1_r;
  logic [SW-1:0]        sum2_r;

  // square-root chain
  logic [RW:0]             s_vld;
  logic [RW:0][2*RW-1:0]   s_n;
  logic [RW:0][RW+1:0]     s_rem;
  logic [RW:0][RW-1:0]     s_root;
  logic [RW:0][PW-1:0]     s_pay;

  logic [CB-1:0]        mod_sat;
  logic [CB-1:0]        mod_r;
  logic                 scl_r;
  logic [3:0][CB-1:0]   magm;

  // divider chain
  logic [DW:0]                d_vld;
  logic [DW:0][CB-1:0]        d_d;
  logic [DW:0][3:0][DW-1:0]   d_dvd;
  logic [DW:0][3:0][CB:0]     d_rem;
  logic [DW:0][3:0][DW-1:0]   d_q;
  logic [DW:0][DPW-1:0]       d_pay;

  logic [3:0][CB-1:0]   raw_e;
  logic                 scl_e;
  logic [3:0][CB-1:0]   res_nxt;
  logic [3:0][DW-1:0]   qs;
  logic [3:0][CB-1:0]   res_r;
  logic [CB-1:0]        magn_r;
  logic                 scl_o_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mod_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_mod_r <= cfg_min_modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
      vm_r <= s_vld[RW];
      vo_r <= d_vld[DW];
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag0[l] = c0_r[l][CB-1] ? (~c0_r[l] + CB'(1)) : c0_r[l];
      magm[l] = cm_r[l][CB-1] ? (~cm_r[l] + CB'(1)) : cm_r[l];
    end
  end

  always_ff @(posedge clk) begin
    c0_r <= {in_comp_z, in_comp_y, in_comp_x, in_comp_w};
    for (int l = 0; l < 4; l++) begin
      sq1_r[l] <= SQW'({{CB{1'b0}}, mag0[l]} * {{CB{1'b0}}, mag0[l]});
    end
    c1_r   <= c0_r;
    sum2_r <= SW'(sq1_r[0]) + SW'(sq1_r[1]) + SW'(sq1_r[2]) + SW'(sq1_r[3]);
    c2_r   <= c1_r;
  end

  assign s_vld[0]  = v2_r;
  assign s_n[0]    = (2*RW)'(sum2_r);
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_pay[0]  = c2_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qn_sqrt_cell #(.RW(RW), .PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (s_vld[k]),
      .n_i    (s_n[k]),
      .rem_i  (s_rem[k]),
      .root_i (s_root[k]),
      .pay_i  (s_pay[k]),
      .vld_o  (s_vld[k+1]),
      .n_o    (s_n[k+1]),
      .rem_o  (s_rem[k+1]),
      .root_o (s_root[k+1]),
      .pay_o  (s_pay[k+1])
    );
  end

  // the root can reach 2^COMP_BITS only when every component is most negative
  assign mod_sat = s_root[RW][RW-1] ? '1 : s_root[RW][CB-1:0];

  always_ff @(posedge clk) begin
    mod_r <= mod_sat;
    scl_r <= (MW'(mod_sat) > MW'(min_mod_r));
    cm_r  <= s_pay[RW];
  end

  assign d_vld[0] = vm_r;
  assign d_d[0]   = mod_r;
  assign d_pay[0] = {scl_r, cm_r};
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      d_dvd[0][l] = DW'(magm[l]) << FRAC_BITS;
      d_rem[0][l] = '0;
      d_q[0][l]   = '0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    qn_div_cell #(.CB(CB), .DW(DW), .PW(DPW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (d_vld[k]),
      .d_i   (d_d[k]),
      .dvd_i (d_dvd[k]),
      .rem_i (d_rem[k]),
      .q_i   (d_q[k]),
      .pay_i (d_pay[k]),
      .vld_o (d_vld[k+1]),
      .d_o   (d_d[k+1]),
      .dvd_o (d_dvd[k+1]),
      .rem_o (d_rem[k+1]),
      .q_o   (d_q[k+1]),
      .pay_o (d_pay[k+1])
    );
  end

  assign raw_e = d_pay[DW][PW-1:0];
  assign scl_e = d_pay[DW][PW];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (raw_e[l][CB-1]) begin
        qs[l]      = (d_q[DW][l] > SIGN_Q) ? SIGN_Q : d_q[DW][l];
        res_nxt[l] = CB'(~qs[l] + DW'(1));
      end else begin
        qs[l]      = (d_q[DW][l] > MAXP_Q) ? MAXP_Q : d_q[DW][l];
        res_nxt[l] = CB'(qs[l]);
      end
      if (!scl_e) begin
        res_nxt[l] = raw_e[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    magn_r  <= d_d[DW];
    scl_o_r <= scl_e;
  end

  assign out_valid      = vo_r;
  assign out_norm_w     = res_r[0];
  assign out_norm_x     = res_r[1];
  assign out_norm_y     = res_r[2];
  assign out_norm_z     = res_r[3];
  assign out_magnitude  = magn_r;
  assign out_was_scaled = scl_o_r;

  `QN_ASSERT_IMP(a_out_from_start, clk, rst_n, out_valid, $past(start, LAT))
  `QN_ASSERT_IMP(a_scaled_nonzero, clk, rst_n, out_valid && out_was_scaled,
    out_magnitude != '0)
  `QN_ASSERT_NXT(a_cfg_taken, clk, rst_n, cfg_valid && cfg_ready,
    min_mod_r == $past(cfg_min_modulus))
endmodule
